### rtl/md5_message_digest_unit_macros.svh
// Assertion macros shared by the MD5 digest unit.
// Depends on nothing; included by the top level only.
`ifndef MD5_MESSAGE_DIGEST_UNIT_MACROS_SVH
`define MD5_MESSAGE_DIGEST_UNIT_MACROS_SVH

// Asserts that a condition implies a consequence in the same cycle.
`define MD5_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Asserts that a condition implies a consequence in the following cycle.
`define MD5_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/md5_pkg.sv
// Package of the MD5 digest unit: payload types, constants and round tables.
// Depends on nothing; used by every module of the unit.
package md5_pkg;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_present;
    logic       message_end;
  } md5_in_t;

  typedef struct packed {
    logic [63:0] digest_first_half;
    logic [63:0] digest_second_half;
  } md5_out_t;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = 2;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [5:0] LenStart = 6'h38;

  function automatic logic [31:0] step_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] step_s(input logic [5:0] i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] step_g(input logic [5:0] i);
    logic [3:0] g;
    unique case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'((5 * i[3:0]) + 1);
      2'd2: g = 4'((3 * i[3:0]) + 5);
      default: g = 4'(7 * i[3:0]);
    endcase
    return g;
  endfunction

endpackage

### rtl/md5_message_digest_unit.sv
// MD5 message digest unit: streams bytes in and returns one 128-bit digest per message.
// Operation: a valid/stall input channel carries one md5_in_t beat per message byte;
// message_end on a beat closes the message, with the byte taken first if present.
// Empty beats (no byte, no end) are accepted and leave all state unchanged.
// A front queue of four beats takes input at one beat per cycle while the back
// runs, unless the queue is full; the back accepts a byte per cycle, unless the output
// register holds a stalled digest, until a 64-byte block fills, then runs the
// 64-step round loop and folds the chaining words. A closing beat pads the block
// byte by byte, runs one or two compressions, and then places the digest in an
// output register. The back takes no bytes while the single shared round unit
// compresses a block.
// The output register holds its beat while out_stall_i is high, and the back waits
// on it; the queue then fills and the input stall rises.
// Reset loads the initial chaining values and clears count and fill position.
module md5_message_digest_unit
  import md5_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  md5_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output md5_out_t out_data_o
);

`include "md5_message_digest_unit_macros.svh"

  logic    full, empty, pop;
  md5_in_t head;

  assign in_stall_o = full;

  md5_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i && !full),
    .wdata_i (in_data_i),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (head)
  );

  md5_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!empty),
    .item_i       (head),
    .item_pop_o   (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_o        (out_data_o)
  );

  `MD5_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, pop, !empty)
  `MD5_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   out_valid_o && $stable(out_data_o))

endmodule

### rtl/md5_fifo.sv
// Short queue of input beats between the front and the back of the MD5 unit.
// Depends on md5_pkg.
module md5_fifo
  import md5_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  md5_in_t wdata_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    empty_o,
  output md5_in_t rdata_o
);

  md5_in_t           mem_q [FifoDepth];
  logic [FifoAw-1:0] wptr_q, rptr_q;
  logic [FifoAw:0]   cnt_q;

  assign full_o  = (cnt_q == (FifoAw+1)'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + {{FifoAw{1'b0}}, push_i} - {{FifoAw{1'b0}}, pop_i};
    end
  end

endmodule

### rtl/md5_core.sv
// Back part of the MD5 unit: block store, padding sequencer and 64-step round loop.
// Depends on md5_pkg.
module md5_core
  import md5_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     item_valid_i,
  input  md5_in_t  item_i,
  output logic     item_pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output md5_out_t out_o
);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StPad   = 5'b00010,
    StRound = 5'b00100,
    StFold  = 5'b01000,
    StEmit  = 5'b10000
  } state_e;

  state_e       state_q, state_d;
  logic [31:0]  words_q [16];
  logic [31:0]  ha_q, hb_q, hc_q, hd_q;
  logic [31:0]  a_q, b_q, c_q, d_q;
  logic [63:0]  bits_q, len_q;
  logic [5:0]   fill_q, step_q;
  logic         padding_q, len_phase_q, closing_q;
  logic         out_valid_q;
  md5_out_t     out_q;

  logic         push_en;
  logic [7:0]   push_val;
  logic [31:0]  f, t, rot, w;
  logic [5:0]   lidx;

  always_comb begin
    unique case (step_q[5:4])
      2'd0: f = (b_q & c_q) | (~b_q & d_q);
      2'd1: f = (b_q & d_q) | (c_q & ~d_q);
      2'd2: f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
    w   = words_q[step_g(step_q)];
    t   = a_q + f + step_k(step_q) + w;
    rot = (t << step_s(step_q)) | (t >> (6'd32 - {1'b0, step_s(step_q)}));
  end

  assign item_pop_o  = (state_q == StIdle) && item_valid_i && !(out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    lidx     = fill_q - LenStart;
    push_en  = 1'b0;
    push_val = item_i.message_byte;
    state_d  = state_q;
    unique case (state_q)
      StIdle: begin
        if (item_pop_o && item_i.byte_present) push_en = 1'b1;
        if (item_pop_o) begin
          if (item_i.byte_present && fill_q == 6'd63) state_d = StRound;
          else if (item_i.message_end) state_d = StPad;
        end
      end
      StPad: begin
        push_en = 1'b1;
        if (!padding_q) push_val = PadByte;
        else if (len_phase_q) push_val = len_q[{lidx[2:0], 3'b000} +: 8];
        else push_val = 8'h00;
        if (fill_q == 6'd63) state_d = StRound;
      end
      StRound: if (step_q == 6'd63) state_d = StFold;
      StFold: begin
        if (len_phase_q) state_d = StEmit;
        else if (closing_q) state_d = StPad;
        else state_d = StIdle;
      end
      StEmit: if (!(out_valid_q && out_stall_i)) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      words_q[fill_q[5:2]][{fill_q[1:0], 3'b000} +: 8] <= push_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ha_q        <= InitA; hb_q <= InitB; hc_q <= InitC; hd_q <= InitD;
      bits_q      <= '0;
      fill_q      <= '0;
      step_q      <= '0;
      padding_q   <= 1'b0;
      len_phase_q <= 1'b0;
      closing_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i && state_q != StEmit) out_valid_q <= 1'b0;
      if (push_en) fill_q <= fill_q + 1'b1;
      unique case (state_q)
        StIdle: begin
          if (item_pop_o) begin
            if (item_i.byte_present) bits_q <= bits_q + 64'd8;
            if (item_i.message_end) begin
              len_q <= item_i.byte_present ? bits_q + 64'd8 : bits_q;
            end
            if (item_i.message_end || (item_i.byte_present && fill_q == 6'd63)) begin
              padding_q <= 1'b0;
              len_phase_q <= 1'b0;
            end
            closing_q <= item_i.message_end;
            a_q <= ha_q; b_q <= hb_q; c_q <= hc_q; d_q <= hd_q;
          end
        end
        StPad: begin
          padding_q <= 1'b1;
          if (fill_q == 6'd55 && padding_q) len_phase_q <= 1'b1;
          if (fill_q == 6'd55 && !padding_q) len_phase_q <= 1'b1;
          a_q <= ha_q; b_q <= hb_q; c_q <= hc_q; d_q <= hd_q;
        end
        StRound: begin
          a_q <= d_q; d_q <= c_q; c_q <= b_q;
          b_q <= b_q + rot;
          step_q <= step_q + 1'b1;
        end
        StFold: begin
          ha_q <= ha_q + a_q; hb_q <= hb_q + b_q;
          hc_q <= hc_q + c_q; hd_q <= hd_q + d_q;
        end
        StEmit: begin
          if (!(out_valid_q && out_stall_i)) begin
            out_valid_q <= 1'b1;
            out_q.digest_first_half  <= {ha_q[7:0], ha_q[15:8], ha_q[23:16], ha_q[31:24],
                                         hb_q[7:0], hb_q[15:8], hb_q[23:16], hb_q[31:24]};
            out_q.digest_second_half <= {hc_q[7:0], hc_q[15:8], hc_q[23:16], hc_q[31:24],
                                         hd_q[7:0], hd_q[15:8], hd_q[23:16], hd_q[31:24]};
            ha_q <= InitA; hb_q <= InitB; hc_q <= InitC; hd_q <= InitD;
            bits_q <= '0;
            fill_q <= '0;
            padding_q <= 1'b0;
            len_phase_q <= 1'b0;
            closing_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### bench/tb.sv
// Self-checking bench for the MD5 digest unit: random and directed byte streams
// are predicted by a behavioral MD5 model and each digest beat is compared.
// Depends on md5_pkg and md5_message_digest_unit.
module tb;
  import md5_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  md5_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  md5_out_t out_data_o;

  md5_message_digest_unit u_top (.*);

  always #4 clk_i = ~clk_i;

  md5_in_t pending_beats[$];
  md5_out_t expected_digests[$];
  int unsigned mismatch_count = 0;
  bit stimulus_done = 1'b0;
  bit hold_receiver = 1'b0;
  int unsigned idle_cycles = 0;

  logic [31:0] hash_words[4];
  logic [7:0] block_bytes[64];
  logic [63:0] message_bits;
  logic [5:0] block_fill;

  function automatic logic [31:0] rotl_word(logic [31:0] x, int unsigned s);
    return (x << s) | (x >> (32 - s));
  endfunction

  task automatic load_initial_hash();
    hash_words[0] = InitA;
    hash_words[1] = InitB;
    hash_words[2] = InitC;
    hash_words[3] = InitD;
    message_bits = '0;
    block_fill = '0;
  endtask

  task automatic compress_block();
    logic [31:0] w[16];
    logic [31:0] a, b, c, d, f, t, k;
    int unsigned g, s;
    int unsigned shifts[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    a = hash_words[0];
    b = hash_words[1];
    c = hash_words[2];
    d = hash_words[3];
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4*i+3], block_bytes[4*i+2], block_bytes[4*i+1], block_bytes[4*i]};
    end
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      k = step_k(6'(i));
      s = shifts[(i / 16) * 4 + i % 4];
      t = a + f + k + w[g];
      a = d;
      d = c;
      c = b;
      b = b + rotl_word(t, s);
    end
    hash_words[0] += a;
    hash_words[1] += b;
    hash_words[2] += c;
    hash_words[3] += d;
  endtask

  task automatic append_byte(logic [7:0] v);
    block_bytes[block_fill] = v;
    block_fill++;
    if (block_fill == 0) compress_block();
  endtask

  task automatic predict_digest(md5_in_t beat);
    logic [63:0] length_bits;
    md5_out_t digest;
    if (beat.byte_present) begin
      append_byte(beat.message_byte);
      message_bits += 64'd8;
    end
    if (beat.message_end) begin
      length_bits = message_bits;
      append_byte(PadByte);
      while (block_fill != LenStart) append_byte(8'h00);
      for (int i = 0; i < 8; i++) append_byte(length_bits[8*i +: 8]);
      for (int i = 0; i < 8; i++) begin
        digest.digest_first_half[63-8*i -: 8] = hash_words[i/4][8*(i%4) +: 8];
        digest.digest_second_half[63-8*i -: 8] = hash_words[2+i/4][8*(i%4) +: 8];
      end
      expected_digests.push_back(digest);
      load_initial_hash();
    end
  endtask

  task automatic queue_beat(logic [7:0] v, logic present, logic last);
    md5_in_t beat;
    beat.message_byte = v;
    beat.byte_present = present;
    beat.message_end = last;
    pending_beats.push_back(beat);
  endtask

  task automatic queue_message(int unsigned len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) queue_beat(8'($urandom), 1'b0, 1'b0);
      if (i == len - 1 && $urandom_range(0, 1)) queue_beat(8'($urandom), 1'b1, 1'b1);
      else queue_beat(8'($urandom), 1'b1, 1'b0);
    end
    if (len == 0 || !pending_beats[$].message_end) queue_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  // Driver: after each accepted beat, the next is offered at once or after a random number of idle cycles.
  int unsigned send_gap = 0;
  bit pause_sender = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_digest(in_data_i);
        void'(pending_beats.pop_front());
        send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (pending_beats.size() == 0 || pause_sender) begin
          in_valid_i <= 1'b0;
        end else if ($urandom_range(0, 3) != 0) begin
          in_data_i <= pending_beats[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end else if (!in_valid_i) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_beats.size() != 0 && !pause_sender) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_beats[0];
        end
      end
    end
  end

  // Monitor: checks digests in order and draws a random stall per beat.
  int unsigned recv_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_digests.size() == 0) begin
          $display("%0t: unexpected digest %h", $time, out_data_o);
          mismatch_count++;
        end else begin
          if (out_data_o.digest_first_half !== expected_digests[0].digest_first_half) begin
            $display("%0t: first half expected %h actual %h", $time,
                     expected_digests[0].digest_first_half, out_data_o.digest_first_half);
            mismatch_count++;
          end
          if (out_data_o.digest_second_half !== expected_digests[0].digest_second_half) begin
            $display("%0t: second half expected %h actual %h", $time,
                     expected_digests[0].digest_second_half, out_data_o.digest_second_half);
            mismatch_count++;
          end
          void'(expected_digests.pop_front());
        end
        recv_gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
      end else if (recv_gap != 0) begin
        recv_gap--;
      end
      out_stall_i <= hold_receiver || recv_gap != 0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    load_initial_hash();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_beat(8'h00, 1'b0, 1'b1);
    queue_beat(8'h00, 1'b0, 1'b0);
    queue_beat(8'hff, 1'b1, 1'b0);
    queue_beat(8'h00, 1'b1, 1'b0);
    queue_beat(8'ha5, 1'b0, 1'b0);
    queue_beat(8'h61, 1'b1, 1'b1);
    queue_beat(8'h5a, 1'b1, 1'b1);
    queue_message(55);
    queue_message(56);
    queue_message(64);

    // Long receiver hold while the sender keeps offering beats.
    hold_receiver = 1'b1;
    for (int m = 0; m < 6; m++) queue_message($urandom_range(0, 3));
    wait (in_valid_i && in_stall_o);
    repeat (400) @(posedge clk_i);
    hold_receiver = 1'b0;

    while (pending_beats.size() != 0 || expected_digests.size() != 0) @(posedge clk_i);
    pause_sender = 1'b1;
    for (int m = 0; m < 3; m++) queue_message($urandom_range(1, 20));
    repeat (20) @(posedge clk_i);
    pause_sender = 1'b0;

    for (int n = 0; n < 1100; ) begin
      int unsigned len;
      len = $urandom_range(0, 7) == 0 ? $urandom_range(60, 130) : $urandom_range(0, 24);
      queue_message(len);
      n += len + 1;
      while (pending_beats.size() > 200) @(posedge clk_i);
    end

    while (pending_beats.size() != 0 || in_valid_i) @(posedge clk_i);
    stimulus_done = 1'b1;
    while (expected_digests.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl
rtl/md5_pkg.sv
rtl/md5_fifo.sv
rtl/md5_core.sv
rtl/md5_message_digest_unit.sv
bench/tb.sv
